@@ rtl/core/ascii_decimal_number_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// ASCII decimal number parser assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_NUMBER_PARSER_UNIT_ASSERT_SVH
`define ASCII_DECIMAL_NUMBER_PARSER_UNIT_ASSERT_SVH

// Condition in the same cycle.
`define ADNP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition in the following cycle.
`define ADNP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/adnp_pkg.sv @@
// ----------------------------------------------------------------------------
// ASCII decimal number parser package
// Types, character codes and register map shared by the parser RTL.
// ----------------------------------------------------------------------------
package adnp_pkg;

	localparam int unsigned ACC_WIDTH_DEF = 32;

	localparam int unsigned PADDR_WIDTH   = 3;
	localparam int unsigned REG_IDX_LSB   = 2;
	localparam logic        REG_FRACTION_MODE = 1'b0;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [3:0] FRAC_MAX = 4'd15;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TIMEOUT = 3'd1,
		ST_LINE    = 3'd2,
		ST_DOTS    = 3'd3,
		ST_NODIG   = 3'd4
	} status_t;

	typedef struct packed {
		logic       func;
		logic [7:0] char_code;
		logic [7:0] line_error;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] mantissa;
		logic [3:0]         frac_digits;
		logic [7:0]         error_flags;
	} result_t;

endpackage

@@ rtl/core/adnp_in_if.sv @@
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries received characters and receiver events.
// ----------------------------------------------------------------------------
interface adnp_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] char_code;
	logic [7:0] line_error;

	modport source (output valid, func, char_code, line_error, input ready);
	modport sink (input valid, func, char_code, line_error, output ready);
endinterface

@@ rtl/core/adnp_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries parsed numbers and their status.
// ----------------------------------------------------------------------------
interface adnp_out_if import adnp_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic signed [31:0] mantissa;
	logic [3:0]         frac_digits;
	logic [7:0]         error_flags;

	modport source (output valid, status, mantissa, frac_digits, error_flags, input ready);
	modport sink (input valid, status, mantissa, frac_digits, error_flags, output ready);
endinterface

@@ rtl/core/adnp_cfg.sv @@
// ----------------------------------------------------------------------------
// Parser configuration registers
// APB-style register port holding the fraction mode bit.
// ----------------------------------------------------------------------------
module adnp_cfg import adnp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_WIDTH-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output logic                   fraction_mode
);
	logic fraction_mode_q;
	logic sel_fraction_mode;

	assign pready            = 1'b1;
	assign sel_fraction_mode = (paddr[REG_IDX_LSB] == REG_FRACTION_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fraction_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && sel_fraction_mode) begin
			fraction_mode_q <= pwdata[0];
		end
	end

	assign prdata        = sel_fraction_mode ? {31'b0, fraction_mode_q} : 32'b0;
	assign fraction_mode = fraction_mode_q;
endmodule

@@ rtl/core/adnp_core.sv @@
// ----------------------------------------------------------------------------
// Parser core
// Input register, number state and the per-character update logic.
// ----------------------------------------------------------------------------
`include "ascii_decimal_number_parser_unit_assert.svh"

module adnp_core import adnp_pkg::*; #(
	parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fraction_mode,
	input  logic    in_valid,
	output logic    in_ready,
	input  item_t   in_item,
	input  logic    out_free,
	output logic    res_load,
	output result_t res_data
);
	logic                 valid_s1;
	item_t                item_s1;

	logic [ACC_WIDTH-1:0] mag_q;
	logic                 neg_q;
	logic                 have_q;
	logic                 seen_q;
	logic [3:0]           cnt_q;

	logic [ACC_WIDTH-1:0] mag_d;
	logic                 neg_d;
	logic                 have_d;
	logic                 seen_d;
	logic [3:0]           cnt_d;

	logic                 emit;
	logic                 fire;
	logic                 is_digit;
	logic [3:0]           digit;
	logic [ACC_WIDTH-1:0] mag_step;
	logic [63:0]          mag_ext;
	logic [31:0]          mag32;
	logic [15:0]          mag16;
	logic [15:0]          val16;
	result_t              res;

	assign is_digit = (item_s1.char_code >= CH_ZERO) && (item_s1.char_code <= CH_NINE);
	assign digit    = 4'(item_s1.char_code - CH_ZERO);
	assign mag_step = (mag_q << 3) + (mag_q << 1) + ACC_WIDTH'(digit);
	assign mag_ext  = 64'(mag_q);
	assign mag32    = neg_q ? (32'd0 - mag_ext[31:0]) : mag_ext[31:0];
	assign mag16    = mag_ext[15:0];
	assign val16    = neg_q ? (16'd0 - mag16) : mag16;

	always_comb begin
		mag_d  = mag_q;
		neg_d  = neg_q;
		have_d = have_q;
		seen_d = seen_q;
		cnt_d  = cnt_q;
		emit   = 1'b0;
		res    = '{status: ST_OK, mantissa: '0, frac_digits: '0, error_flags: '0};
		if (item_s1.func) begin
			emit       = 1'b1;
			res.status = ST_TIMEOUT;
		end else if (item_s1.line_error != 8'd0) begin
			emit            = 1'b1;
			res.status      = ST_LINE;
			res.error_flags = item_s1.line_error;
		end else if (!have_q && item_s1.char_code == CH_PLUS) begin
			neg_d = 1'b0;
		end else if (!have_q && item_s1.char_code == CH_MINUS) begin
			neg_d = 1'b1;
		end else if (!have_q && (item_s1.char_code == CH_SPACE ||
				item_s1.char_code == CH_TAB)) begin
			neg_d = neg_q;
		end else if (item_s1.char_code == CH_POINT && fraction_mode) begin
			if (seen_q) begin
				emit       = 1'b1;
				res.status = ST_DOTS;
			end else begin
				seen_d = 1'b1;
			end
		end else if (is_digit) begin
			mag_d  = mag_step;
			have_d = 1'b1;
			if (seen_q && cnt_q != FRAC_MAX) begin
				cnt_d = cnt_q + 4'd1;
			end
		end else if (!have_q) begin
			emit       = 1'b1;
			res.status = ST_NODIG;
		end else begin
			emit = 1'b1;
			if (fraction_mode) begin
				res.mantissa    = mag32;
				res.frac_digits = cnt_q;
			end else begin
				res.mantissa = {{16{val16[15]}}, val16};
			end
		end
		if (emit) begin
			mag_d  = '0;
			neg_d  = 1'b0;
			have_d = 1'b0;
			seen_d = 1'b0;
			cnt_d  = 4'd0;
		end
	end

	assign fire     = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || fire;
	assign res_load = fire && emit;
	assign res_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			have_q   <= 1'b0;
			seen_q   <= 1'b0;
			cnt_q    <= 4'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				mag_q  <= mag_d;
				neg_q  <= neg_d;
				have_q <= have_d;
				seen_q <= seen_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	`ADNP_ASSERT_NXT(a_clear_after_result, clk, arst_n, res_load, (mag_q == '0 && !neg_q && !have_q && !seen_q && cnt_q == 4'd0), "Number state not cleared after a result.")
	`ADNP_ASSERT_IMP(a_frac_needs_point, clk, arst_n, cnt_q != 4'd0, seen_q, "Fraction digits counted without a decimal point.")
	`ADNP_ASSERT_IMP(a_mag_needs_digit, clk, arst_n, !have_q, mag_q == '0, "Magnitude is nonzero before any digit.")
	`ADNP_ASSERT_NXT(a_stall_holds_item, clk, arst_n, valid_s1 && !fire, (valid_s1 && $stable(item_s1)), "Stalled item was lost or changed.")
endmodule

@@ rtl/core/adnp_out_reg.sv @@
// ----------------------------------------------------------------------------
// Parser result register
// Holds one finished result until the result channel takes it.
// ----------------------------------------------------------------------------
module adnp_out_reg import adnp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t data,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);
	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule

@@ rtl/core/ascii_decimal_number_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ASCII decimal number parser unit
// Assembles signed decimal numbers from received characters.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// char_in   sink       func, char_code, line_error
// result    source     status, mantissa, frac_digits, error_flags
// APB       slave      fraction_mode at byte address 0
//
// One item is accepted every cycle while the input register is not stalled;
// the item that ends a number passes from the input register into the result
// register, which then holds its result as valid.
// The digit update is a shift-and-add on the accumulator between those two.
// Reset clears the number state, the fraction mode and both valid flags.
// A stalled result holds the input register only when the next item also ends
// a number; other items keep flowing.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser_unit import adnp_pkg::*; #(
	parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	adnp_in_if.sink                char_in,
	adnp_out_if.source             result,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_WIDTH-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	logic    fraction_mode;
	item_t   in_item;
	logic    res_load;
	result_t res_data;
	logic    out_free;
	result_t out_data;

	assign in_item = '{func: char_in.func, char_code: char_in.char_code,
		line_error: char_in.line_error};

	adnp_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.fraction_mode (fraction_mode)
	);

	adnp_core #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fraction_mode (fraction_mode),
		.in_valid      (char_in.valid),
		.in_ready      (char_in.ready),
		.in_item       (in_item),
		.out_free      (out_free),
		.res_load      (res_load),
		.res_data      (res_data)
	);

	adnp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.data      (res_data),
		.free      (out_free),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	assign result.status      = out_data.status;
	assign result.mantissa    = out_data.mantissa;
	assign result.frac_digits = out_data.frac_digits;
	assign result.error_flags = out_data.error_flags;
endmodule
